>>> sv/brlt_pkg.sv
// ----------------------------------------------------------------------------
// brlt_pkg: shared types and constants for the byte range lock table
// Holds the request and response word layouts, action and status codes and
// the table geometry defaults.
// ----------------------------------------------------------------------------
package brlt_pkg;

  localparam int OffsetBits  = 48;
  localparam int EndBits     = OffsetBits + 2;  // signed inclusive end, may be -1
  localparam int SlotFieldW  = 4;
  localparam int SlotsDefault = 16;

  localparam logic [1:0] ActAcquire = 2'd0;
  localparam logic [1:0] ActRelease = 2'd1;
  localparam logic [1:0] ActCheck   = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StConflict = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [OffsetBits-1:0] offset;
    logic [OffsetBits-1:0] length;
    logic [SlotFieldW-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SlotFieldW-1:0] slot_index;
  } rsp_t;

endpackage

>>> sv/byte_range_lock_table_top.sv
// ----------------------------------------------------------------------------
// byte_range_lock_table_top: byte range lock table
// Keeps SLOTS held byte ranges; acquires, checks and releases them one word
// per cycle.
// ----------------------------------------------------------------------------
// A request word is taken at every rising edge with start high; busy is tied
// low, so the block takes one word in every cycle with no gaps. Each word
// gives exactly one response word: done comes from the response register
// behind the request register, is high for a single cycle, and rsp is valid
// only in that cycle. The receiver cannot hold responses off, so it must
// capture rsp whenever done is high. The rate is set by one pass through the
// SLOTS range comparators and the lowest-free-slot priority encoder between
// the request register and the response register; the table update of one
// word is seen by the word right behind it. Acquire stores [offset,
// offset+length-1] in the lowest free slot when no held range overlaps;
// conflict wins over full. Check runs the same test and claims nothing.
// Release frees the named slot; a slot number at or above SLOTS is ignored.
// ----------------------------------------------------------------------------
module byte_range_lock_table_top #(
  parameter int SLOTS = brlt_pkg::SlotsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  brlt_pkg::req_t req,
  output logic           done,
  output brlt_pkg::rsp_t rsp
);
  import brlt_pkg::*;

  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WideW = (IdxW > SlotFieldW) ? IdxW : SlotFieldW;
  localparam logic [WideW:0] SlotsVal = (WideW+1)'(SLOTS);

  // table
  logic [SLOTS-1:0]             entry_valid;
  logic [OffsetBits-1:0]        entry_start [SLOTS];
  logic signed [EndBits-1:0]    entry_end   [SLOTS];

  // request register
  logic                         req_valid;
  logic [1:0]                   req_action;
  logic [OffsetBits-1:0]        req_lo;
  logic signed [EndBits-1:0]    req_hi;
  logic [SlotFieldW-1:0]        req_slot;

  logic [EndBits-1:0]           hi_next;

  // lookup results
  logic                         hit;
  logic                         have_free;
  logic [IdxW-1:0]              free_idx;
  logic [WideW-1:0]             free_wide;
  logic [WideW-1:0]             slot_wide;
  logic [IdxW-1:0]              rel_idx;
  logic                         slot_in_range;
  logic                         grant;
  logic                         release_en;
  rsp_t                         rsp_next;

  assign busy = 1'b0;

  // Form the inclusive end at accept time so the compare pass has no adder.
  assign hi_next = EndBits'({2'b00, req.offset}) + EndBits'({2'b00, req.length})
                   - EndBits'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start & ~busy;
    end
    req_action <= req.action;
    req_lo     <= req.offset;
    req_hi     <= signed'(hi_next);
    req_slot   <= req.slot;
  end

  // Scan every slot in parallel: overlap against held ranges, lowest free.
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        have_free = 1'b1;
        free_idx  = IdxW'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (entry_valid[i]
          && signed'({2'b00, req_lo}) <= entry_end[i]
          && req_hi >= signed'({2'b00, entry_start[i]})) begin
        hit = 1'b1;
      end
    end
  end

  assign free_wide     = WideW'(free_idx);
  assign slot_wide     = WideW'(req_slot);
  assign rel_idx       = slot_wide[IdxW-1:0];
  assign slot_in_range = {1'b0, slot_wide} < SlotsVal;

  always_comb begin
    rsp_next   = '0;
    grant      = 1'b0;
    release_en = 1'b0;
    case (req_action)
      ActAcquire, ActCheck: begin
        if (hit) begin
          rsp_next.status = StConflict;
        end else if (!have_free) begin
          rsp_next.status = StFull;
        end else begin
          rsp_next.status     = StOk;
          rsp_next.slot_index = free_wide[SlotFieldW-1:0];
          grant               = req_valid && (req_action == ActAcquire);
        end
      end
      ActRelease: begin
        rsp_next.status     = StOk;
        rsp_next.slot_index = req_slot;
        release_en          = req_valid && slot_in_range;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // Claim or free a slot; visible to the next word in the request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (grant) begin
      entry_valid[free_idx] <= 1'b1;
    end else if (release_en) begin
      entry_valid[rel_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grant) begin
      entry_start[free_idx] <= req_lo;
      entry_end[free_idx]   <= req_hi;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
    rsp <= rsp_next;
  end

endmodule

>>> test/byte_range_lock_table_top_tb.sv
// ----------------------------------------------------------------------------
// byte_range_lock_table_top_tb: self-checking bench for the byte range lock table
// Drives acquire, check, release and no-op words through the command port.
// It predicts each response from a private copy of the table, and compares
// every strobed response in order, with and without idle gaps on the sender.
// ----------------------------------------------------------------------------
module byte_range_lock_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brlt_pkg::*;

  localparam int          Slots      = SlotsDefault;
  localparam logic [1:0]  ActNop     = 2'd3;  // unused code, must answer 0/0
  localparam logic [47:0] MaxOfs     = {OffsetBits{1'b1}};
  localparam int          PhaseWords = 312;
  localparam int          CycleLimit = 200000;
  localparam int          DrainWait  = 8;     // quiet edges after the last response, as margin

  // --------------------------------------------------------------------------
  // Scoreboard: shadow table, expected responses in order, error count
  // --------------------------------------------------------------------------
  class lock_scoreboard;
    bit                         held [Slots];
    logic [OffsetBits-1:0]      first_byte [Slots];
    logic signed [EndBits-1:0]  last_byte [Slots];
    rsp_t                       due_q [$];
    int errors, checked;
    int n_granted, n_conflict, n_full, n_release, n_check, n_nop;

    function new();
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    task report(input string msg);
      if (errors < 100) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // Advance the shadow table by one accepted word and queue its response.
    function void note(input req_t w);
      rsp_t                      e;
      logic signed [EndBits-1:0] lo, hi;
      int                        free_slot;
      bit                        hit;
      e = '0;
      case (w.action)
        ActAcquire, ActCheck: begin
          lo = $signed({2'b00, w.offset});
          hi = $signed({2'b00, w.offset}) + $signed({2'b00, w.length}) - 1;
          free_slot = -1;
          hit = 1'b0;
          for (int i = 0; i < Slots; i++) begin
            if (!held[i]) begin
              if (free_slot < 0) free_slot = i;
            end else if (lo <= last_byte[i] && hi >= $signed({2'b00, first_byte[i]})) begin
              hit = 1'b1;
            end
          end
          if (w.action == ActCheck) n_check++;
          if (hit) begin
            e.status = StConflict;
            n_conflict++;
          end else if (free_slot < 0) begin
            e.status = StFull;
            n_full++;
          end else begin
            e.status = StOk;
            e.slot_index = free_slot[SlotFieldW-1:0];
            if (w.action == ActAcquire) begin
              held[free_slot] = 1'b1;
              first_byte[free_slot] = w.offset;
              last_byte[free_slot] = hi;
              n_granted++;
            end
          end
        end
        ActRelease: begin
          if (int'(w.slot) < Slots) held[w.slot] = 1'b0;
          e.slot_index = w.slot;
          n_release++;
        end
        default: n_nop++;
      endcase
      due_q.push_back(e);
    endfunction

    // Compare one strobed response with the oldest expectation.
    task check(input rsp_t got);
      rsp_t e;
      if (due_q.size() == 0) begin
        report($sformatf("response %0d/%0d with nothing pending", got.status, got.slot_index));
      end else begin
        e = due_q.pop_front();
        checked++;
        if (got.status !== e.status)
          report($sformatf("status %0d, expected %0d", got.status, e.status));
        if (got.slot_index !== e.slot_index)
          report($sformatf("slot_index %0d, expected %0d", got.slot_index, e.slot_index));
      end
    endtask

    function int pending();
      return due_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;

  lock_scoreboard sb = new();
  int cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  byte_range_lock_table_top #(.SLOTS(Slots)) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // Capture every strobed response: the receiver cannot stall, so sample each edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check(rsp);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d responses pending", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Build one random word. Most ranges fall in a small window near zero so
  // that overlaps, refusals and a full table happen often; the rest sit at the
  // top of the offset space or span the whole width.
  function automatic req_t make_word();
    req_t w;
    int   pick, area;
    pick = $urandom_range(0, 99);
    area = $urandom_range(0, 99);
    if (pick < 45)      w.action = ActAcquire;
    else if (pick < 75) w.action = ActRelease;
    else if (pick < 95) w.action = ActCheck;
    else                w.action = ActNop;
    w.slot = SlotFieldW'($urandom_range(0, Slots - 1));
    if (area < 65) begin
      w.offset = 48'($urandom_range(0, 1023));
      w.length = 48'($urandom_range(0, 16));
    end else if (area < 80) begin
      w.offset = MaxOfs - 48'($urandom_range(0, 1023));
      w.length = 48'($urandom_range(0, 2047));
    end else if (area < 92) begin
      w.offset = rand48();
      w.length = rand48();
    end else begin
      w.offset = 48'($urandom_range(0, 1023));
      w.length = rand48();
    end
    return w;
  endfunction

  // Present a word at the falling edge and hold it until the block takes it.
  task automatic send_word(input req_t w);
    @(negedge clk);
    req   <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(w);
  endtask

  task automatic send_fields(input logic [1:0] act, input logic [47:0] ofs,
                             input logic [47:0] len, input int slot);
    req_t w;
    w.action = act;
    w.offset = ofs;
    w.length = len;
    w.slot   = SlotFieldW'(slot);
    send_word(w);
  endtask

  // With pct chance, drop start before the next word; scramble req meanwhile,
  // since it must be ignored while start is low.
  task automatic maybe_idle(input int pct);
    int n;
    if ($urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 5);
      @(negedge clk);
      start <= 1'b0;
      req   <= make_word();
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int idle_pct [4] = '{0, 54, 0, 8};

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero-length ranges, widest values, edges touching, conflict,
    // full table, conflict taking priority over full, release of a free
    // slot, and the unused action code.
    send_fields(ActAcquire, 48'd0, 48'd0, 0);      // end below start, slot 0
    send_fields(ActCheck,   48'd0, 48'd0, 0);      // empty range overlaps nothing
    send_fields(ActAcquire, 48'd0, 48'd1, 0);      // [0,0] in slot 1
    send_fields(ActCheck,   48'd0, 48'd1, 0);      // conflict
    send_fields(ActAcquire, MaxOfs, MaxOfs, 0);    // end past the offset width
    send_fields(ActCheck,   MaxOfs, 48'd0, 0);     // empty range right at a start
    send_fields(ActCheck,   MaxOfs - 1, 48'd2, 0); // one byte into the top range
    send_fields(ActNop,     rand48(), rand48(), 15);
    send_fields(ActRelease, rand48(), rand48(), 5);  // already free
    send_fields(ActRelease, 48'd0, 48'd0, 0);
    for (int i = 0; i < Slots - 2; i++)
      send_fields(ActAcquire, 48'(100 + 10 * i), 48'd10, 0);
    send_fields(ActAcquire, 48'd5000, 48'd5, 0);   // no overlap, table full
    send_fields(ActAcquire, 48'd0, 48'd1, 0);      // overlap wins over full

    // Random: four phases with sender gap rates of 0, 54, 0 and 8 percent; the
    // receiver never stalls, so two of the phases run with no sender gaps.
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < PhaseWords; k++) begin
        maybe_idle(idle_pct[p]);
        send_word(make_word());
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for every pending response, then DrainWait quiet edges.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Covered %0d words: %0d granted, %0d conflicts, %0d full,",
             sb.checked, sb.n_granted, sb.n_conflict, sb.n_full);
    $display("  %0d checks, %0d releases, %0d no-ops; gaps 0/54/0/8 pct, %0d cycles, %0d errors",
             sb.n_check, sb.n_release, sb.n_nop, cycles, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> byte_range_lock_table_top.f
sv/brlt_pkg.sv
sv/byte_range_lock_table_top.sv
test/byte_range_lock_table_top_tb.sv
